// ===== rtl/sjb_pkg.sv =====
// Serial jitter buffer: shared types and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sjb_pkg;

	// Field and counter widths fixed by the item format
	localparam int PW_W   = 16;
	localparam int TICK_W = 20;
	localparam int FILL_W = 9;
	localparam int STAT_W = 32;
	localparam int SKIP_W = 4;

	// Input item kinds
	localparam logic [1:0] MODE_BYTE  = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_START = 2'd2;
	localparam logic [1:0] MODE_STOP  = 2'd3;

	// Service timing
	localparam logic [PW_W-1:0] PW_MIN      = 16'd40;
	localparam logic [PW_W-1:0] PW_FALLBACK = 16'd12000;

	// Buffering thresholds
	localparam int                FILL_MARK = 8;
	localparam logic [SKIP_W-1:0] SKIP_LIMIT = 4'd8;
	localparam logic [SKIP_W-1:0] SKIP_MAX   = 4'd9;

	// Command handed from the front to the back
	typedef enum logic [1:0] {
		OP_NOP,
		OP_BYTE,
		OP_SERVICE,
		OP_START
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sjb_if.sv =====
// Serial jitter buffer: channel interfaces (input items, results, configuration).
// Depends on sjb_pkg for field widths.
`default_nettype none

interface sjb_in_if import sjb_pkg::*;;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] data_byte;

	modport source (output valid, mode, data_byte, input ready);
	modport sink (input valid, mode, data_byte, output ready);
endinterface

interface sjb_out_if import sjb_pkg::*;;
	logic              valid;
	logic              ready;
	logic              delivered;
	logic [7:0]        rx_byte;
	logic              dropped;
	logic              buffering_now;
	logic [FILL_W-1:0] fill_level;
	logic [STAT_W-1:0] lost_total;
	logic [STAT_W-1:0] processed_total;
	logic [STAT_W-1:0] received_total;

	modport source (output valid, delivered, rx_byte, dropped, buffering_now, fill_level,
		lost_total, processed_total, received_total, input ready);
	modport sink (input valid, delivered, rx_byte, dropped, buffering_now, fill_level,
		lost_total, processed_total, received_total, output ready);
endinterface

interface sjb_cfg_if import sjb_pkg::*;;
	logic            valid;
	logic            ready;
	logic [PW_W-1:0] pulse_width;

	modport source (output valid, pulse_width, input ready);
	modport sink (input valid, pulse_width, output ready);
endinterface

`default_nettype wire

// ===== rtl/sjb_front.sv =====
// Serial jitter buffer front: accepts items, runs the session tick countdown
// and turns each item into one command for the back. Depends on sjb_pkg, sjb_if.
`default_nettype none

module sjb_front import sjb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	sjb_in_if.sink    item_in,
	sjb_cfg_if.sink   cfg,
	output logic      push_valid,
	input  wire logic push_ready,
	output cmd_t      push_cmd
);

	logic [PW_W-1:0]   pulse_width_q;
	logic              session_q;
	logic [TICK_W-1:0] ticks_q;
	logic [PW_W-1:0]   pw_eff;
	logic [TICK_W-1:0] interval;
	logic              accept;
	logic              fire;

	assign cfg.ready     = 1'b1;
	assign item_in.ready = push_ready;
	assign push_valid    = item_in.valid;
	assign accept        = item_in.valid && push_ready;

	// Service interval: eight bit periods, small widths fall back to the default
	assign pw_eff   = (pulse_width_q < PW_MIN) ? PW_FALLBACK : pulse_width_q;
	assign interval = {1'b0, pw_eff, 3'b000};
	assign fire     = session_q && (ticks_q <= TICK_W'(1));

	// Classify the item
	always_comb begin
		push_cmd.data = item_in.data_byte;
		unique case (item_in.mode)
			MODE_BYTE:  push_cmd.op = OP_BYTE;
			MODE_TICK:  push_cmd.op = fire ? OP_SERVICE : OP_NOP;
			MODE_START: push_cmd.op = OP_START;
			MODE_STOP:  push_cmd.op = OP_NOP;
			default:    push_cmd.op = OP_NOP;
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_width_q <= PW_FALLBACK;
		end else if (cfg.valid) begin
			pulse_width_q <= cfg.pulse_width;
		end
	end

	// Session state and tick countdown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q <= 1'b0;
			ticks_q   <= '0;
		end else if (accept) begin
			unique case (item_in.mode)
				MODE_BYTE: begin
				end
				MODE_TICK: begin
					if (session_q) begin
						ticks_q <= fire ? interval : ticks_q - TICK_W'(1);
					end
				end
				MODE_START: begin
					session_q <= 1'b1;
					ticks_q   <= TICK_W'(1);
				end
				MODE_STOP: begin
					session_q <= 1'b0;
					ticks_q   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sjb_queue.sv =====
// Serial jitter buffer: two-entry command queue between front and back.
// Depends on sjb_pkg.
`default_nettype none

module sjb_queue import sjb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cmd_t push_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cmd_t      pop_cmd
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sjb_back.sv =====
// Serial jitter buffer back: byte store, buffering control, statistics, result
// register. One command per cycle while results drain. Depends on sjb_pkg, sjb_if.
`default_nettype none

module sjb_back import sjb_pkg::*; #(
	parameter int FIFO_DEPTH = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	output logic      pop_ready,
	input  wire cmd_t pop_cmd,
	sjb_out_if.source result_out
);

	localparam int ADDR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

	logic [7:0]        mem [FIFO_DEPTH];
	logic [7:0]        rdata_q;
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              buf_q;
	logic [SKIP_W-1:0] skip_q;
	logic [STAT_W-1:0] lost_q;
	logic [STAT_W-1:0] proc_q;
	logic [STAT_W-1:0] recv_q;
	logic              out_valid_q;
	logic              delivered_q;
	logic              dropped_q;
	logic [SKIP_W-1:0] skip_next;
	logic              exec;
	logic              full;
	logic              do_write;
	logic              do_read;

	// A command executes only when the result slot is free or being drained,
	// so the state always matches the result on display
	assign pop_ready = !out_valid_q || result_out.ready;
	assign exec      = pop_valid && pop_ready;
	assign full      = (count_q == CNT_W'(FIFO_DEPTH));
	assign do_write  = exec && (pop_cmd.op == OP_BYTE) && !full;
	assign do_read   = exec && (pop_cmd.op == OP_SERVICE) && (count_q != '0) && !buf_q;
	assign skip_next = (skip_q < SKIP_MAX) ? skip_q + SKIP_W'(1) : skip_q;

	// Byte store
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_ptr_q] <= pop_cmd.data;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	// Result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			delivered_q <= 1'b0;
			dropped_q   <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
			delivered_q <= do_read;
			dropped_q   <= exec && (pop_cmd.op == OP_BYTE) && full;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// FIFO control, buffering mode and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			buf_q    <= 1'b0;
			skip_q   <= '0;
			lost_q   <= '0;
			proc_q   <= '0;
			recv_q   <= '0;
		end else if (exec) begin
			unique case (pop_cmd.op)
				OP_NOP: begin
				end
				OP_BYTE: begin
					recv_q <= recv_q + STAT_W'(1);
					if (full) begin
						lost_q <= lost_q + STAT_W'(1);
					end else begin
						wr_ptr_q <= (wr_ptr_q == ADDR_W'(FIFO_DEPTH - 1)) ? '0
							: wr_ptr_q + ADDR_W'(1);
						count_q <= count_q + CNT_W'(1);
						if (count_q >= CNT_W'(FILL_MARK - 1)) buf_q <= 1'b0;
					end
				end
				OP_SERVICE: begin
					priority if (count_q == '0) begin
						buf_q <= 1'b1;
					end else if (buf_q) begin
						// skipped service while buffering
						skip_q <= skip_next;
						if (skip_next > SKIP_LIMIT) buf_q <= 1'b0;
					end else begin
						rd_ptr_q <= (rd_ptr_q == ADDR_W'(FIFO_DEPTH - 1)) ? '0
							: rd_ptr_q + ADDR_W'(1);
						count_q <= count_q - CNT_W'(1);
						proc_q  <= proc_q + STAT_W'(1);
						skip_q  <= '0;
					end
				end
				OP_START: begin
					skip_q <= '0;
					lost_q <= '0;
					proc_q <= '0;
					recv_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Result fields
	assign result_out.valid           = out_valid_q;
	assign result_out.delivered       = delivered_q;
	assign result_out.rx_byte         = delivered_q ? rdata_q : 8'd0;
	assign result_out.dropped         = dropped_q;
	assign result_out.buffering_now   = buf_q;
	assign result_out.fill_level      = FILL_W'(count_q);
	assign result_out.lost_total      = lost_q;
	assign result_out.processed_total = proc_q;
	assign result_out.received_total  = recv_q;

endmodule

`default_nettype wire

// ===== rtl/serial_jitter_buffer_unit.sv =====
// Serial jitter buffer: top level (front, command queue, back).
// Depends on sjb_pkg, sjb_if, sjb_front, sjb_queue, sjb_back.
//
// Channels: item_in carries one item per transaction (mode, data_byte): a link
// byte, a clock tick, a session start or a session stop. result_out returns
// exactly one result per item, in order: delivered/rx_byte from a service
// step, dropped on overflow, buffering_now, fill_level and the three 32-bit
// session counters. cfg writes pulse_width; it is always ready and is meant
// to be written only while no item is in flight.
// Path: each item's command is registered in the command queue, then the back
// executes it into its result register.
// Throughput: while results drain, one item per cycle; the back executes one
// command per cycle, one byte-store access; front countdown is one subtract.
// Reset: pointers, fill level, buffering flag, session and counters clear,
// pulse_width returns to 12000; the byte store itself is not cleared.
// Receiver stall: the result register holds, the back stops, the two-entry
// queue fills, and item_in.ready then drops until results drain.
`default_nettype none

module serial_jitter_buffer_unit import sjb_pkg::*; #(
	parameter int FIFO_DEPTH = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sjb_in_if.sink    item_in,
	sjb_out_if.source result_out,
	sjb_cfg_if.sink   cfg
);

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic back_valid;
	logic back_ready;
	cmd_t back_cmd;

	sjb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.cfg        (cfg),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd)
	);

	sjb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	sjb_back #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd),
		.result_out (result_out)
	);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for serial_jitter_buffer_unit: directed table, then random phases at several pulse
// widths, with every result checked field by field against a jitter buffer predictor or a typed-in value.
// Depends on sjb_pkg, the sjb channel interfaces and the RTL of the block.

module tb;
	import sjb_pkg::*;

	localparam int          STORE_DEPTH      = 256;
	localparam int          STORE_AW         = $clog2(STORE_DEPTH);
	localparam int          PHASES           = 10;
	localparam int unsigned BITS_PER_SERVICE = 8;
	localparam int unsigned CYCLE_LIMIT      = 8_000_000;
	localparam int unsigned LONG_HOLD        = 300;

	typedef struct packed {
		logic              delivered;
		logic [7:0]        rx_byte;
		logic              dropped;
		logic              buffering_now;
		logic [FILL_W-1:0] fill_level;
		logic [STAT_W-1:0] lost_total;
		logic [STAT_W-1:0] processed_total;
		logic [STAT_W-1:0] received_total;
	} jb_result_t;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] data;
		bit         typed;
		jb_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sjb_in_if  item_in();
	sjb_out_if result_out();
	sjb_cfg_if cfg();

	serial_jitter_buffer_unit #(.FIFO_DEPTH(STORE_DEPTH)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	always #4 clk = ~clk;

	// Jitter buffer predictor state, mirrors the block after reset
	logic [7:0]        fifo_mem [STORE_DEPTH];
	int unsigned       rd_ptr = 0;
	int unsigned       wr_ptr = 0;
	int unsigned       held = 0;
	bit                buffering = 1'b0;
	logic [SKIP_W-1:0] skips = '0;
	bit                in_session = 1'b0;
	int unsigned       countdown = 0;
	logic [STAT_W-1:0] lost_cnt = '0;
	logic [STAT_W-1:0] delivered_cnt = '0;
	logic [STAT_W-1:0] recv_cnt = '0;
	logic [PW_W-1:0]   pw_reg = PW_FALLBACK;

	jb_result_t  expected_results[$];
	stim_row_t   directed_rows[$];
	logic [15:0] phase_pw [PHASES];
	int unsigned error_count = 0;
	int unsigned result_count = 0;
	int unsigned cycle_count = 0;

	// Idle control shared by the sender and the receiver
	bit          quiet = 1'b0;
	bit          src_idle_on = 1'b1;
	bit          sink_idle_on = 1'b1;
	int unsigned src_cool = 0;
	int unsigned hold_request = 0;

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Expected outcome of one item; advances the predictor state
	function automatic jb_result_t predict_item(input logic [1:0] kind, input logic [7:0] data);
		jb_result_t      r;
		logic [PW_W-1:0] width;
		r = '0;
		case (kind)
			MODE_BYTE: begin
				recv_cnt++;
				if (held == STORE_DEPTH) begin
					lost_cnt++;
					r.dropped = 1'b1;
				end else begin
					fifo_mem[STORE_AW'(wr_ptr)] = data;
					wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
					held++;
					if (held >= FILL_MARK) buffering = 1'b0;
				end
			end
			MODE_TICK: begin
				if (in_session && countdown > 1) begin
					countdown--;
				end else if (in_session) begin
					// service step
					if (held == 0) begin
						buffering = 1'b1;
					end else if (buffering) begin
						if (skips < SKIP_MAX) skips++;
						if (skips > SKIP_LIMIT) buffering = 1'b0;
					end else begin
						r.delivered = 1'b1;
						r.rx_byte = fifo_mem[STORE_AW'(rd_ptr)];
						rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
						held--;
						delivered_cnt++;
						skips = '0;
					end
					width = pw_reg;
					if (width < PW_MIN) width = PW_FALLBACK;
					countdown = BITS_PER_SERVICE * 32'(width);
				end
			end
			MODE_START: begin
				skips = '0;
				lost_cnt = '0;
				delivered_cnt = '0;
				recv_cnt = '0;
				in_session = 1'b1;
				countdown = 1;
			end
			default: begin
				in_session = 1'b0;
				countdown = 0;
			end
		endcase
		r.buffering_now = buffering;
		r.fill_level = FILL_W'(held);
		r.lost_total = lost_cnt;
		r.processed_total = delivered_cnt;
		r.received_total = recv_cnt;
		return r;
	endfunction

	function automatic jb_result_t mk_result(input logic dlv, input logic [7:0] rx,
		input logic drop, input logic buf_on, input int unsigned fill,
		input int unsigned lost, input int unsigned proc, input int unsigned recv);
		jb_result_t r;
		r.delivered = dlv;
		r.rx_byte = rx;
		r.dropped = drop;
		r.buffering_now = buf_on;
		r.fill_level = FILL_W'(fill);
		r.lost_total = lost;
		r.processed_total = proc;
		r.received_total = recv;
		return r;
	endfunction

	function automatic void add_row(input logic [1:0] kind, input logic [7:0] data,
		input bit typed, input jb_result_t res);
		stim_row_t row;
		row.kind = kind;
		row.data = data;
		row.typed = typed;
		row.res = res;
		directed_rows.push_back(row);
	endfunction

	// One input transaction, with an occasional idle burst ahead of it.
	// Called at a falling edge, returns at the falling edge after acceptance.
	task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
		input bit typed, input jb_result_t typed_res);
		jb_result_t predicted;
		if (!quiet && src_idle_on && src_cool == 0 && $urandom_range(0, 5) == 0) begin
			item_in.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
			src_cool = 8;
		end else if (src_cool != 0) begin
			src_cool--;
		end
		item_in.valid <= 1'b1;
		item_in.mode <= kind;
		item_in.data_byte <= data;
		do @(posedge clk); while (!item_in.ready);
		predicted = predict_item(kind, data);
		expected_results.push_back(typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got %0h, expected %0h",
				result_count, name, got, want));
	endtask

	// Result collection and comparison
	always @(posedge clk) begin
		jb_result_t got;
		jb_result_t want;
		if (arst_n && result_out.valid && result_out.ready) begin
			got.delivered = result_out.delivered;
			got.rx_byte = result_out.rx_byte;
			got.dropped = result_out.dropped;
			got.buffering_now = result_out.buffering_now;
			got.fill_level = result_out.fill_level;
			got.lost_total = result_out.lost_total;
			got.processed_total = result_out.processed_total;
			got.received_total = result_out.received_total;
			if (expected_results.size() == 0) begin
				report_error($sformatf("result %0d arrived with nothing expected", result_count));
			end else begin
				want = expected_results.pop_front();
				check_field("delivered", 32'(got.delivered), 32'(want.delivered));
				check_field("rx_byte", 32'(got.rx_byte), 32'(want.rx_byte));
				check_field("dropped", 32'(got.dropped), 32'(want.dropped));
				check_field("buffering_now", 32'(got.buffering_now),
					32'(want.buffering_now));
				check_field("fill_level", 32'(got.fill_level), 32'(want.fill_level));
				check_field("lost_total", got.lost_total, want.lost_total);
				check_field("processed_total", got.processed_total, want.processed_total);
				check_field("received_total", got.received_total, want.received_total);
			end
			result_count++;
		end
	end

	// Receiver: random stall bursts, plus a long hold-off on request
	initial begin
		int unsigned stall_left;
		int unsigned hold_left;
		int unsigned cool;
		stall_left = 0;
		hold_left = 0;
		cool = 0;
		result_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				result_out.ready <= 1'b0;
				hold_left--;
			end else if (stall_left != 0) begin
				result_out.ready <= 1'b0;
				stall_left--;
				if (stall_left == 0) cool = 8;
			end else if (!quiet && sink_idle_on && cool == 0 && $urandom_range(0, 5) == 0) begin
				result_out.ready <= 1'b0;
				stall_left = $urandom_range(1, 11) - 1;
				if (stall_left == 0) cool = 8;
			end else begin
				result_out.ready <= 1'b1;
				if (cool != 0) cool--;
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
		$display("DONE: errors detected");
		$finish;
	end

	// Stimulus
	initial begin
		int unsigned n;
		int unsigned pick;
		int unsigned byte_w;
		int unsigned segs;
		bit          drain;
		bit          huge;
		bit          flood_ok;

		item_in.valid = 1'b0;
		item_in.mode = MODE_BYTE;
		item_in.data_byte = '0;
		cfg.valid = 1'b0;
		cfg.pulse_width = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset pulse width; obvious outcomes typed in
		add_row(MODE_TICK, 8'h00, 1, mk_result(0, 8'h00, 0, 0, 0, 0, 0, 0));
		add_row(MODE_STOP, 8'h00, 1, mk_result(0, 8'h00, 0, 0, 0, 0, 0, 0));
		add_row(MODE_BYTE, 8'h00, 1, mk_result(0, 8'h00, 0, 0, 1, 0, 0, 1));
		add_row(MODE_BYTE, 8'hFF, 1, mk_result(0, 8'h00, 0, 0, 2, 0, 0, 2));
		add_row(MODE_START, 8'hC3, 1, mk_result(0, 8'h00, 0, 0, 2, 0, 0, 0));
		add_row(MODE_TICK, 8'h00, 1, mk_result(1, 8'h00, 0, 0, 1, 0, 1, 0));
		// countdown running, then a restart mid-session
		add_row(MODE_TICK, 8'hFF, 0, '0);
		add_row(MODE_START, 8'h00, 0, '0);
		add_row(MODE_TICK, 8'h00, 0, '0);
		// service on an empty store enters buffering
		add_row(MODE_START, 8'h00, 0, '0);
		add_row(MODE_TICK, 8'h00, 0, '0);
		add_row(MODE_BYTE, 8'h5A, 0, '0);
		// stop: ticks ignored, buffering survives a new start
		add_row(MODE_STOP, 8'hFF, 0, '0);
		add_row(MODE_TICK, 8'h00, 0, '0);
		add_row(MODE_START, 8'h00, 0, '0);
		add_row(MODE_TICK, 8'h00, 0, '0);
		// fill to the mark, leaving buffering
		add_row(MODE_BYTE, 8'h80, 0, '0);
		add_row(MODE_BYTE, 8'h01, 0, '0);
		add_row(MODE_BYTE, 8'h02, 0, '0);
		add_row(MODE_BYTE, 8'h04, 0, '0);
		add_row(MODE_BYTE, 8'h08, 0, '0);
		add_row(MODE_BYTE, 8'h10, 0, '0);
		add_row(MODE_BYTE, 8'h20, 0, '0);
		add_row(MODE_START, 8'h00, 0, '0);
		add_row(MODE_TICK, 8'h00, 0, '0);
		foreach (directed_rows[i])
			send_item(directed_rows[i].kind, directed_rows[i].data,
				directed_rows[i].typed, directed_rows[i].res);
		item_in.valid <= 1'b0;

		// Random phases, one pulse width each, extremes and fallback included
		phase_pw = '{16'd40, 16'd0, 16'd40, 16'd65535, 16'd41, 16'd39,
			16'($urandom_range(41, 80)), 16'd40, 16'($urandom_range(1, 38)), 16'd40};
		for (int ph = 0; ph < PHASES; ph++) begin
			// register write only with nothing in flight
			wait (expected_results.size() == 0);
			@(negedge clk);
			cfg.valid <= 1'b1;
			cfg.pulse_width <= phase_pw[ph];
			do @(posedge clk); while (!cfg.ready);
			pw_reg = phase_pw[ph];
			@(negedge clk);
			cfg.valid <= 1'b0;

			huge = (phase_pw[ph] < PW_MIN) || (phase_pw[ph] > 16'd1000);
			drain = huge || ph == 2 || ph == 6 || ph == PHASES - 1;
			flood_ok = (ph == 7);
			byte_w = drain ? 7 : 30;
			segs = huge ? 4 : 10;
			quiet = (ph == PHASES - 1);
			src_idle_on = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			if (ph == 0 || ph == 4) hold_request = LONG_HOLD;

			send_item(MODE_START, 8'($urandom_range(0, 255)), 0, '0);
			// one full service interval at the shortest width
			if (ph == 0)
				repeat (BITS_PER_SERVICE * PW_MIN + 2)
					send_item(MODE_TICK, 8'($urandom_range(0, 255)), 0, '0);
			for (int s = 0; s < segs; s++) begin
				pick = $urandom_range(0, 99);
				if (flood_ok && s == segs / 2) begin
					// overrun the store so bytes get dropped at full level
					n = STORE_DEPTH - held + $urandom_range(1, 6);
					repeat (n) send_item(MODE_BYTE, 8'($urandom_range(0, 255)), 0, '0);
				end else if (pick < 3 + byte_w) begin
					repeat ($urandom_range(1, 6))
						send_item(MODE_BYTE, 8'($urandom_range(0, 255)), 0, '0);
				end else if (pick < 90) begin
					repeat ($urandom_range(1, 16))
						send_item(MODE_TICK, 8'($urandom_range(0, 255)), 0, '0);
				end else if (pick < 94) begin
					send_item(MODE_START, 8'($urandom_range(0, 255)), 0, '0);
				end else if (pick < 95) begin
					send_item(MODE_STOP, 8'($urandom_range(0, 255)), 0, '0);
				end else begin
					send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 0, '0);
				end
			end
			item_in.valid <= 1'b0;
		end

		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
